/* hdl/lz77d_pkg.sv */
package lz77d_pkg;

   // History window
   localparam int HIST_DEPTH = 4096;
   localparam int HIST_AW    = $clog2(HIST_DEPTH);

   // Reference encoding
   localparam int LEN_BIAS   = 3;
   localparam int FLAG_TOP   = 7;
   localparam int LEN_W      = 5;
   localparam int DIST_W     = 12;
   localparam int SIZE_W     = 24;

   typedef struct packed {
      logic [7:0] byte_in;
      logic       start_stream;
   } req_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       last_of_run;
      logic       stream_done;
   } rsp_type;

   typedef enum logic [3:0] {
      PH_CLEAR,
      PH_HDR0,
      PH_HDR1,
      PH_HDR2,
      PH_HDR3,
      PH_FLAG,
      PH_LIT,
      PH_REF0,
      PH_REF1,
      PH_COPY
   } phase_type;

endpackage

/* hdl/lz77_stream_decompressor.sv */
// LZ77 (type 10h) stream decompressor. Compressed bytes enter one per req_
// transaction, header included; decompressed bytes leave one per rsp_
// transaction. Header, flag and first-reference bytes give no result; a
// literal gives one byte; the second byte of a reference starts a copy that
// reads the 4096-byte history memory once per cycle while the emit stage has
// room. The single history read port limits the copy to that rate. A copy
// whose distance is zero reads the byte being written in the same cycle and is
// served by forwarding inside the memory. After reset the block clears all
// 4096 history entries, one entry a cycle, with req_ready low. The window
// is never cleared between streams, so a reference reaching before the start
// of a stream returns older data. The output register lets the next transaction
// start while a finished byte waits for rsp_ready.
module lz77_stream_decompressor (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  lz77d_pkg::req_type req_data,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output lz77d_pkg::rsp_type rsp_data
);
   import lz77d_pkg::*;

   localparam logic [HIST_AW:0]   DEPTH_W = (HIST_AW+1)'(HIST_DEPTH);
   localparam logic [HIST_AW-1:0] TOP_A   = HIST_AW'(HIST_DEPTH - 1);

   // Control and datapath state
   phase_type          phase_ff, phase_in;
   logic [SIZE_W-1:0]  remaining_ff, remaining_in;
   logic [7:0]         flag_bits_ff, flag_bits_in;
   logic [2:0]         flag_idx_ff, flag_idx_in;
   logic [7:0]         ref_first_ff, ref_first_in;
   logic [DIST_W-1:0]  dist_ff, dist_in;
   logic [LEN_W-1:0]   len_ff, len_in;
   logic [HIST_AW-1:0] wpos_ff, wpos_in;
   logic [HIST_AW-1:0] clr_ff, clr_in;

   // Emit stage: holds one byte between the history read and the output
   logic               s1_valid_ff, s1_valid_in;
   logic               s1_lit_ff;
   logic [7:0]         s1_byte_ff;
   logic               s1_last_ff;
   logic               s1_done_ff;
   logic [HIST_AW-1:0] s1_addr_ff;

   logic               rsp_valid_ff, rsp_valid_in;
   rsp_type            rsp_data_ff;

   // Handshake and sequencing
   logic               req_fire;
   phase_type          eff_phase;
   logic               out_free;
   logic               s1_move;
   logic               s1_free;
   logic               issue_lit;
   logic               issue_copy;
   logic               issue;
   logic               issue_done;
   logic               issue_last;

   // History port
   logic               ram_we;
   logic [HIST_AW-1:0] ram_waddr;
   logic [7:0]         ram_wdata;
   logic [HIST_AW-1:0] ram_raddr;
   logic [7:0]         ram_rdata;
   logic [7:0]         s1_out_byte;
   logic [HIST_AW:0]   src_sum;

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign s1_move   = s1_valid_ff && out_free;
   assign s1_free   = !s1_valid_ff || s1_move;
   assign eff_phase = req_data.start_stream ? PH_HDR0 : phase_ff;
   assign req_fire  = req_valid && req_ready;

   // Outputs of the sequencer
   always_comb begin
      req_ready  = 1'b0;
      issue_copy = 1'b0;
      unique case (phase_ff)
         PH_CLEAR: begin
            req_ready = 1'b0;
         end
         PH_COPY: begin
            issue_copy = s1_free;
         end
         PH_LIT: begin
            // hold the literal until the emit stage has room
            req_ready = s1_free;
         end
         default: begin
            req_ready = 1'b1;
         end
      endcase
   end

   assign issue_lit  = req_fire && (eff_phase == PH_LIT);
   assign issue      = issue_lit || issue_copy;
   assign issue_done = (remaining_ff == SIZE_W'(1));
   assign issue_last = issue_lit || issue_done || (len_ff == LEN_W'(1));

   // Copy source: write position minus distance minus one, modulo the depth
   assign src_sum   = {1'b0, wpos_ff} + (DEPTH_W - 1'b1 - (HIST_AW+1)'(dist_ff));
   assign ram_raddr = (src_sum >= DEPTH_W) ? HIST_AW'(src_sum - DEPTH_W)
                                           : src_sum[HIST_AW-1:0];

   // Next state
   always_comb begin
      phase_in     = phase_ff;
      remaining_in = remaining_ff;
      flag_bits_in = flag_bits_ff;
      flag_idx_in  = flag_idx_ff;
      ref_first_in = ref_first_ff;
      dist_in      = dist_ff;
      len_in       = len_ff;
      wpos_in      = wpos_ff;
      clr_in       = clr_ff;

      if (req_fire) begin
         unique case (eff_phase)
            PH_HDR0: begin
               phase_in = PH_HDR1;
            end
            PH_HDR1: begin
               remaining_in = {16'd0, req_data.byte_in};
               phase_in     = PH_HDR2;
            end
            PH_HDR2: begin
               remaining_in = {8'd0, req_data.byte_in, remaining_ff[7:0]};
               phase_in     = PH_HDR3;
            end
            PH_HDR3: begin
               remaining_in = {req_data.byte_in, remaining_ff[15:0]};
               // drop a stream of size zero straight away
               phase_in = ({req_data.byte_in, remaining_ff[15:0]} == '0) ? PH_HDR0
                                                                         : PH_FLAG;
            end
            PH_FLAG: begin
               flag_bits_in = req_data.byte_in;
               flag_idx_in  = 3'(FLAG_TOP);
               phase_in     = req_data.byte_in[FLAG_TOP] ? PH_REF0 : PH_LIT;
            end
            PH_LIT: begin
               if (issue_done) begin
                  phase_in = PH_HDR0;
               end else if (flag_idx_ff == '0) begin
                  phase_in = PH_FLAG;
               end else begin
                  flag_idx_in = flag_idx_ff - 1'b1;
                  phase_in    = flag_bits_ff[flag_idx_ff - 1'b1] ? PH_REF0 : PH_LIT;
               end
            end
            PH_REF0: begin
               ref_first_in = req_data.byte_in;
               phase_in     = PH_REF1;
            end
            PH_REF1: begin
               dist_in  = {ref_first_ff[3:0], req_data.byte_in};
               len_in   = LEN_W'(ref_first_ff[7:4]) + LEN_W'(LEN_BIAS);
               phase_in = PH_COPY;
            end
            default: begin
               phase_in = phase_ff;
            end
         endcase
      end else if (phase_ff == PH_COPY) begin
         if (issue_copy) begin
            len_in = len_ff - 1'b1;
            if (issue_done) begin
               // drop the rest of the reference at the end of the stream
               phase_in = PH_HDR0;
            end else if (len_ff == LEN_W'(1)) begin
               if (flag_idx_ff == '0) begin
                  phase_in = PH_FLAG;
               end else begin
                  flag_idx_in = flag_idx_ff - 1'b1;
                  phase_in    = flag_bits_ff[flag_idx_ff - 1'b1] ? PH_REF0 : PH_LIT;
               end
            end
         end
      end else if (phase_ff == PH_CLEAR) begin
         clr_in = clr_ff + 1'b1;
         if (clr_ff == TOP_A) begin
            phase_in = PH_HDR0;
         end
      end

      if (issue) begin
         remaining_in = remaining_ff - 1'b1;
         wpos_in      = (wpos_ff == TOP_A) ? '0 : wpos_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_CLEAR;
         remaining_ff <= '0;
         flag_bits_ff <= '0;
         flag_idx_ff  <= 3'(FLAG_TOP);
         ref_first_ff <= '0;
         dist_ff      <= '0;
         len_ff       <= '0;
         wpos_ff      <= '0;
         clr_ff       <= '0;
      end else begin
         phase_ff     <= phase_in;
         remaining_ff <= remaining_in;
         flag_bits_ff <= flag_bits_in;
         flag_idx_ff  <= flag_idx_in;
         ref_first_ff <= ref_first_in;
         dist_ff      <= dist_in;
         len_ff       <= len_in;
         wpos_ff      <= wpos_in;
         clr_ff       <= clr_in;
      end
   end

   // Emit stage: load on issue, release into the output register
   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (issue) begin
         s1_valid_in = 1'b1;
      end else if (s1_move) begin
         s1_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (issue) begin
         s1_lit_ff  <= issue_lit;
         s1_byte_ff <= req_data.byte_in;
         s1_last_ff <= issue_last;
         s1_done_ff <= issue_done;
         s1_addr_ff <= wpos_ff;
      end
   end

   assign s1_out_byte = s1_lit_ff ? s1_byte_ff : ram_rdata;

   // History write: clearing pass after reset, then each byte as it leaves
   always_comb begin
      if (phase_ff == PH_CLEAR) begin
         ram_we    = 1'b1;
         ram_waddr = clr_ff;
         ram_wdata = '0;
      end else begin
         ram_we    = s1_move;
         ram_waddr = s1_addr_ff;
         ram_wdata = s1_out_byte;
      end
   end

   lz77d_hist_ram u_hist (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_en   (issue_copy),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   // Output register
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (s1_move) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_move) begin
         rsp_data_ff.out_byte    <= s1_out_byte;
         rsp_data_ff.last_of_run <= s1_last_ff;
         rsp_data_ff.stream_done <= s1_done_ff;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // The byte that closes a stream always closes its transaction's run
   a_done_is_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.stream_done) |-> rsp_data.last_of_run)
      else $error("stream_done without last_of_run");

   // No input is taken while a copy or the clearing pass runs
   a_no_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == PH_COPY || phase_ff == PH_CLEAR) |-> !req_ready)
      else $error("input accepted while busy");

   // A copy never runs with an exhausted length
   a_copy_len: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == PH_COPY) |-> (len_ff != '0))
      else $error("copy with zero length left");

   // Every issued byte reaches the output: the emit stage is never overwritten
   a_s1_no_overrun: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && !out_free) |-> !issue)
      else $error("emit stage overwritten");

endmodule

/* hdl/lz77d_hist_ram.sv */
module lz77d_hist_ram (
   input  logic                        clock,
   input  logic                        wr_en,
   input  logic [lz77d_pkg::HIST_AW-1:0] wr_addr,
   input  logic [7:0]                  wr_data,
   input  logic                        rd_en,
   input  logic [lz77d_pkg::HIST_AW-1:0] rd_addr,
   output logic [7:0]                  rd_data
);
   import lz77d_pkg::*;

   logic [7:0] mem [HIST_DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // Forward the byte being written when a copy reads it in the same cycle
   always_ff @(posedge clock) begin
      if (rd_en) begin
         if (wr_en && (wr_addr == rd_addr)) begin
            rd_data <= wr_data;
         end else begin
            rd_data <= mem[rd_addr];
         end
      end
   end

endmodule

/* dv/lz77_checker.sv */
module lz77_checker
   import lz77d_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   input  logic    req_ready,
   input  req_type req_data,
   input  logic    rsp_valid,
   input  logic    rsp_ready,
   input  rsp_type rsp_data,
   output int      fail_count,
   output int      outstanding
);

   phase_type           phase;
   logic [SIZE_W-1:0]   remaining;
   logic [7:0]          flag_bits;
   logic [2:0]          flag_index;
   logic [7:0]          ref_first;
   logic [7:0]          history [HIST_DEPTH];
   logic [HIST_AW-1:0]  write_pos;
   rsp_type             expected_bytes [$];
   rsp_type             run_bytes [$];
   rsp_type             want;

   function automatic phase_type bit_phase();
      return flag_bits[flag_index] ? PH_REF0 : PH_LIT;
   endfunction

   task automatic advance_block();
      if (flag_index == 0) begin
         phase = PH_FLAG;
      end else begin
         flag_index = flag_index - 1'b1;
         phase = bit_phase();
      end
   endtask

   // Write one byte to the window and queue it; true when the size runs out.
   function automatic bit emit_byte(input logic [7:0] value);
      rsp_type r;
      history[write_pos] = value;
      write_pos = write_pos + 1'b1;
      remaining = remaining - 1'b1;
      r.out_byte    = value;
      r.last_of_run = 1'b0;
      r.stream_done = (remaining == 0);
      run_bytes.push_back(r);
      if (remaining == 0) phase = PH_HDR0;
      return (remaining == 0);
   endfunction

   task automatic decode_byte(input req_type item);
      logic [LEN_W-1:0]    copy_len;
      logic [DIST_W-1:0]   ref_dist;
      logic [HIST_AW-1:0]  rd;
      bit                  done;
      int                  i;
      run_bytes.delete();
      done = 1'b0;
      if (item.start_stream) phase = PH_HDR0;
      case (phase)
         PH_HDR0: phase = PH_HDR1;
         PH_HDR1: begin
            remaining = {16'h0, item.byte_in};
            phase = PH_HDR2;
         end
         PH_HDR2: begin
            remaining[15:8] = item.byte_in;
            phase = PH_HDR3;
         end
         PH_HDR3: begin
            remaining[23:16] = item.byte_in;
            phase = (remaining == 0) ? PH_HDR0 : PH_FLAG;
         end
         PH_FLAG: begin
            flag_bits  = item.byte_in;
            flag_index = 3'(FLAG_TOP);
            phase = bit_phase();
         end
         PH_LIT: begin
            if (!emit_byte(item.byte_in)) advance_block();
         end
         PH_REF0: begin
            ref_first = item.byte_in;
            phase = PH_REF1;
         end
         PH_REF1: begin
            copy_len = LEN_W'(ref_first[7:4]) + LEN_W'(LEN_BIAS);
            ref_dist = {ref_first[3:0], item.byte_in};
            for (i = 0; i < copy_len && !done; i++) begin
               rd = write_pos - ref_dist - 1'b1;
               done = emit_byte(history[rd]);
            end
            if (!done) advance_block();
         end
         default: phase = PH_HDR0;
      endcase
      if (run_bytes.size() > 0) run_bytes[run_bytes.size() - 1].last_of_run = 1'b1;
      foreach (run_bytes[k]) expected_bytes.push_back(run_bytes[k]);
   endtask

   always @(posedge clock) begin
      if (reset) begin
         phase      = PH_HDR0;
         remaining  = '0;
         flag_bits  = '0;
         flag_index = 3'(FLAG_TOP);
         ref_first  = '0;
         write_pos  = '0;
         foreach (history[k]) history[k] = '0;
         expected_bytes.delete();
         fail_count = 0;
      end else begin
         // Check the result first: a byte accepted now cannot stem from this edge's input.
         if (rsp_valid && rsp_ready) begin
            if (expected_bytes.size() == 0) begin
               $error("out_byte: expected none, actual %02h", rsp_data.out_byte);
               fail_count++;
            end else begin
               want = expected_bytes.pop_front();
               if (rsp_data.out_byte !== want.out_byte) begin
                  $error("out_byte: expected %02h, actual %02h",
                         want.out_byte, rsp_data.out_byte);
                  fail_count++;
               end
               if (rsp_data.last_of_run !== want.last_of_run) begin
                  $error("last_of_run: expected %0b, actual %0b",
                         want.last_of_run, rsp_data.last_of_run);
                  fail_count++;
               end
               if (rsp_data.stream_done !== want.stream_done) begin
                  $error("stream_done: expected %0b, actual %0b",
                         want.stream_done, rsp_data.stream_done);
                  fail_count++;
               end
            end
         end
         if (req_valid && req_ready) decode_byte(req_data);
      end
      outstanding <= expected_bytes.size();
   end

endmodule

/* dv/tb_top.sv */
module tb_top;
   import lz77d_pkg::*;

   logic    clock     = 1'b0;
   logic    reset     = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_ready;
   req_type req_data  = '0;
   logic    rsp_valid;
   logic    rsp_ready = 1'b0;
   rsp_type rsp_data;

   int fail_count;
   int outstanding;
   int items_sent   = 0;
   int req_idle_max = 5;
   int rsp_idle_max = 5;
   // Body transactions left before a stream is cut short; negative means no cut.
   int cut_budget   = -1;
   // Set when the last stream ended exactly, so the next header needs no start flag.
   bit clean_end    = 1'b0;
   bit pressure_done = 1'b0;

   lz77_stream_decompressor u_top (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   lz77_checker u_checker (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_data    (rsp_data),
      .fail_count  (fail_count),
      .outstanding (outstanding)
   );

   initial begin
      forever #10 clock = ~clock;
   end

   // Give up long after the slowest legal run would have finished.
   initial begin
      #5_000_000;
      $display("lz77_stream_decompressor regression: fail");
      $finish;
   end

   // Result side: stall for a random number of cycles before each transaction.
   initial begin
      int gap;
      @(posedge clock);
      forever begin
         gap = $urandom_range(0, rsp_idle_max);
         if (gap != 0) begin
            rsp_ready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!rsp_valid);
      end
   end

   // Offer one compressed byte and hold it until the block takes it. Leave
   // valid high on return, so a back-to-back byte needs only one assignment.
   task automatic send_item(input logic [7:0] value, input logic first);
      int gap;
      gap = $urandom_range(0, req_idle_max);
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= '{byte_in: value, start_stream: first};
      do @(posedge clock); while (!req_ready);
      items_sent++;
   endtask

   task automatic send_body(input logic [7:0] value);
      send_item(value, 1'b0);
      if (cut_budget > 0) cut_budget--;
   endtask

   task automatic send_header(input logic [7:0] lead_byte, input logic first,
                              input logic [23:0] size);
      send_item(lead_byte, first);
      send_item(size[7:0], 1'b0);
      send_item(size[15:8], 1'b0);
      send_item(size[23:16], 1'b0);
   endtask

   // Drop valid and hold off until every predicted byte has come back.
   task automatic wait_drained();
      req_valid <= 1'b0;
      do @(posedge clock); while (outstanding != 0);
   endtask

   // Build a well-formed stream on the fly: random flags, literals and
   // references, stopping once the declared size is covered or the cut hits.
   // A long stream is also cut once the item count is well past its target.
   task automatic send_stream(input logic [23:0] size, input logic first);
      int         produced;
      int         b;
      logic [7:0] flags;
      logic [3:0] len_nib;
      logic [11:0] back_dist;
      produced = 0;
      send_header(8'($urandom_range(0, 255)), first, size);
      while (produced < size && cut_budget != 0 && items_sent < 300) begin
         flags = 8'($urandom_range(0, 255));
         send_body(flags);
         for (b = 7; b >= 0 && produced < size && cut_budget != 0; b--) begin
            if (flags[b]) begin
               len_nib = 4'($urandom_range(0, 15));
               // Mostly short distances into fresh output; now and then far
               // back into stale window contents.
               if ($urandom_range(0, 3) == 0) back_dist = 12'($urandom_range(0, 4095));
               else back_dist = 12'($urandom_range(0, 15));
               send_body({len_nib, back_dist[11:8]});
               if (cut_budget != 0) begin
                  send_body(back_dist[7:0]);
                  produced += len_nib + 3;
               end
            end else begin
               send_body(8'($urandom_range(0, 255)));
               produced++;
            end
         end
      end
      clean_end = (produced >= size);
   endtask

   initial begin
      logic first;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // Zero size: the header alone ends the stream.
      send_header(8'h00, 1'b1, 24'h000000);

      // Largest size. Long overlapping copy of the zeroed window, a literal,
      // then the farthest distance reading a never-written stale entry.
      send_header(8'hFF, 1'b1, 24'hFFFFFF);
      send_item(8'hA0, 1'b0);
      send_item(8'hF0, 1'b0);
      send_item(8'h00, 1'b0);
      send_item(8'hFF, 1'b0);
      send_item(8'h0F, 1'b0);
      send_item(8'hFF, 1'b0);

      // Restart mid-stream; a size of five runs out inside a reference.
      send_header(8'h10, 1'b1, 24'h000005);
      send_item(8'h40, 1'b0);
      send_item(8'hAA, 1'b0);
      send_item(8'hF0, 1'b0);
      send_item(8'h00, 1'b0);

      // After a clean end the next byte is header byte 0 without a start flag.
      send_header(8'h20, 1'b0, 24'h000001);
      send_item(8'h00, 1'b0);
      send_item(8'h55, 1'b0);
      clean_end = 1'b1;

      wait_drained();

      while (items_sent < 280) begin
         // Pick idling per stream so some stretches run flat out.
         req_idle_max = ($urandom_range(0, 3) == 0) ? 0 : 5;
         rsp_idle_max = ($urandom_range(0, 3) == 0) ? 0 : 5;
         if (!pressure_done && items_sent >= 150) begin
            wait_drained();
            pressure_done = 1'b1;
         end
         first = clean_end ? logic'($urandom_range(0, 1)) : 1'b1;
         case ($urandom_range(0, 9))
            0: begin
               // Noise: random bytes with the odd stray start flag.
               repeat ($urandom_range(1, 8))
                  send_item(8'($urandom_range(0, 255)), $urandom_range(0, 7) == 0);
               clean_end = 1'b0;
            end
            1: begin
               cut_budget = $urandom_range(1, 12);
               send_stream(24'($urandom_range(1, 60)), first);
               cut_budget = -1;
            end
            2: send_stream(24'h000000, first);
            3: send_stream(24'($urandom_range(41, 400)), first);
            default: send_stream(24'($urandom_range(1, 40)), first);
         endcase
      end

      wait_drained();
      repeat (40) @(posedge clock);
      if (fail_count == 0 && outstanding == 0) begin
         $display("lz77_stream_decompressor regression: pass");
      end else begin
         $display("lz77_stream_decompressor regression: fail");
      end
      $finish;
   end

endmodule
